@@ hw/rtl/i2cram_pkg.sv @@
`default_nettype none

package i2cram_pkg;

  // Command codes carried on op
  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CfgSetup      = 3'd0;
  localparam logic [2:0] CfgWriteBit   = 3'd1;
  localparam logic [2:0] CfgReadBit    = 3'd2;
  localparam logic [2:0] CfgMasterAck  = 3'd3;
  localparam logic [2:0] CfgAckTimeout = 3'd4;

  // Reset values of the timing registers
  localparam logic [7:0] SetupReset      = 8'd4;
  localparam logic [7:0] WriteBitReset   = 8'd2;
  localparam logic [7:0] ReadBitReset    = 8'd50;
  localparam logic [7:0] MasterAckReset  = 8'd5;
  localparam logic [7:0] AckTimeoutReset = 8'd250;

  // Bits per byte on the bus
  localparam logic [3:0] BitsPerByte = 4'd8;

  // Byte sequence positions
  localparam logic [1:0] ByteDev  = 2'd0;
  localparam logic [1:0] ByteReg  = 2'd1;
  localparam logic [1:0] ByteLast = 2'd2;

  typedef enum logic [4:0] {
    PhIdle    = 5'd0,
    PhStartA  = 5'd1,
    PhStartB  = 5'd2,
    PhStartC  = 5'd3,
    PhBitA    = 5'd4,
    PhBitB    = 5'd5,
    PhBitC    = 5'd6,
    PhAckA    = 5'd7,
    PhAckB    = 5'd8,
    PhAckPoll = 5'd9,
    PhRdA     = 5'd10,
    PhRdB     = 5'd11,
    PhNkA     = 5'd12,
    PhNkB     = 5'd13,
    PhStopA   = 5'd14,
    PhStopB   = 5'd15,
    PhStopC   = 5'd16
  } phase_e;

  typedef struct packed {
    logic [7:0] setup;
    logic [7:0] write_bit;
    logic [7:0] read_bit;
    logic [7:0] master_ack;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] tick_cnt;
    logic [3:0] bit_cnt;
    logic [1:0] byte_idx;
    logic [7:0] shift;
    logic       is_read;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wdata;
    logic [7:0] read_byte;
    logic       err;
  } state_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy;
    logic       done;
    logic       ack_error;
    logic [7:0] rdata;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/i2cram_step.sv @@
`default_nettype none

// One tick or command of the bus sequencer: next state and the line levels
module i2cram_step (
  input  var i2cram_pkg::state_t cur_i,
  input  var i2cram_pkg::cfg_t   cfg_i,
  input  wire logic [1:0]        op_i,
  input  wire logic [6:0]        dev_addr_i,
  input  wire logic [7:0]        reg_addr_i,
  input  wire logic [7:0]        wdata_i,
  input  wire logic              sda_in_i,
  output i2cram_pkg::state_t     nxt_o,
  output i2cram_pkg::res_t       res_o
);

  logic [7:0] dur;
  logic [7:0] tick_inc;
  logic       elapsed;
  logic [3:0] bit_inc;
  logic [7:0] shift_in;
  logic       done;

  // Phase duration selection and the shared tick comparator
  always_comb begin
    case (cur_i.phase)
      i2cram_pkg::PhBitA, i2cram_pkg::PhBitB, i2cram_pkg::PhBitC: dur = cfg_i.write_bit;
      i2cram_pkg::PhRdA, i2cram_pkg::PhRdB:                       dur = cfg_i.read_bit;
      i2cram_pkg::PhNkA, i2cram_pkg::PhNkB:                       dur = cfg_i.master_ack;
      default:                                                    dur = cfg_i.setup;
    endcase
  end

  assign tick_inc = cur_i.tick_cnt + 8'd1;
  assign elapsed  = tick_inc >= dur;
  assign bit_inc  = cur_i.bit_cnt + 4'd1;
  assign shift_in = {cur_i.shift[6:0], sda_in_i};

  // Next state
  always_comb begin
    nxt_o = cur_i;
    done  = 1'b0;
    if (cur_i.phase == i2cram_pkg::PhIdle) begin
      if (op_i == i2cram_pkg::OpWrite || op_i == i2cram_pkg::OpRead) begin
        nxt_o.dev_addr = dev_addr_i;
        nxt_o.reg_addr = reg_addr_i;
        nxt_o.wdata    = wdata_i;
        nxt_o.is_read  = (op_i == i2cram_pkg::OpRead);
        nxt_o.err      = 1'b0;
        nxt_o.byte_idx = i2cram_pkg::ByteDev;
        nxt_o.bit_cnt  = 4'd0;
        nxt_o.shift    = 8'd0;
        nxt_o.phase    = i2cram_pkg::PhStartA;
        nxt_o.tick_cnt = 8'd0;
      end
    end else begin
      case (cur_i.phase)
        i2cram_pkg::PhStartA, i2cram_pkg::PhStartB, i2cram_pkg::PhBitA,
        i2cram_pkg::PhBitB, i2cram_pkg::PhAckA, i2cram_pkg::PhAckB,
        i2cram_pkg::PhRdA, i2cram_pkg::PhNkA, i2cram_pkg::PhNkB,
        i2cram_pkg::PhStopA, i2cram_pkg::PhStopB: begin
          nxt_o.tick_cnt = tick_inc;
          if (elapsed) begin
            nxt_o.tick_cnt = 8'd0;
            case (cur_i.phase)
              i2cram_pkg::PhStartA: nxt_o.phase = i2cram_pkg::PhStartB;
              i2cram_pkg::PhStartB: nxt_o.phase = i2cram_pkg::PhStartC;
              i2cram_pkg::PhBitA:   nxt_o.phase = i2cram_pkg::PhBitB;
              i2cram_pkg::PhBitB:   nxt_o.phase = i2cram_pkg::PhBitC;
              i2cram_pkg::PhAckA:   nxt_o.phase = i2cram_pkg::PhAckB;
              i2cram_pkg::PhAckB:   nxt_o.phase = i2cram_pkg::PhAckPoll;
              i2cram_pkg::PhRdA:    nxt_o.phase = i2cram_pkg::PhRdB;
              i2cram_pkg::PhNkA:    nxt_o.phase = i2cram_pkg::PhNkB;
              i2cram_pkg::PhNkB:    nxt_o.phase = i2cram_pkg::PhStopA;
              i2cram_pkg::PhStopA:  nxt_o.phase = i2cram_pkg::PhStopB;
              default:              nxt_o.phase = i2cram_pkg::PhStopC;
            endcase
          end
        end
        i2cram_pkg::PhStartC: begin
          nxt_o.tick_cnt = tick_inc;
          if (elapsed) begin
            // address byte, read bit set on the second address phase
            nxt_o.shift    = {cur_i.dev_addr, cur_i.byte_idx == i2cram_pkg::ByteLast};
            nxt_o.bit_cnt  = 4'd0;
            nxt_o.phase    = i2cram_pkg::PhBitA;
            nxt_o.tick_cnt = 8'd0;
          end
        end
        i2cram_pkg::PhBitC: begin
          nxt_o.tick_cnt = tick_inc;
          if (elapsed) begin
            nxt_o.shift    = {cur_i.shift[6:0], 1'b0};
            nxt_o.bit_cnt  = bit_inc;
            nxt_o.phase    = (bit_inc >= i2cram_pkg::BitsPerByte) ?
                             i2cram_pkg::PhAckA : i2cram_pkg::PhBitA;
            nxt_o.tick_cnt = 8'd0;
          end
        end
        i2cram_pkg::PhAckPoll: begin
          if (!sda_in_i) begin
            // target acked: pick the next step of the sequence
            nxt_o.tick_cnt = 8'd0;
            if (cur_i.byte_idx == i2cram_pkg::ByteDev) begin
              nxt_o.byte_idx = i2cram_pkg::ByteReg;
              nxt_o.shift    = cur_i.reg_addr;
              nxt_o.bit_cnt  = 4'd0;
              nxt_o.phase    = i2cram_pkg::PhBitA;
            end else if (cur_i.byte_idx == i2cram_pkg::ByteReg) begin
              nxt_o.byte_idx = i2cram_pkg::ByteLast;
              if (cur_i.is_read) begin
                nxt_o.phase = i2cram_pkg::PhStartA;
              end else begin
                nxt_o.shift   = cur_i.wdata;
                nxt_o.bit_cnt = 4'd0;
                nxt_o.phase   = i2cram_pkg::PhBitA;
              end
            end else if (cur_i.is_read) begin
              nxt_o.bit_cnt = 4'd0;
              nxt_o.shift   = 8'd0;
              nxt_o.phase   = i2cram_pkg::PhRdA;
            end else begin
              nxt_o.phase = i2cram_pkg::PhStopA;
            end
          end else if (cur_i.tick_cnt >= cfg_i.ack_timeout) begin
            nxt_o.err      = 1'b1;
            nxt_o.phase    = i2cram_pkg::PhStopA;
            nxt_o.tick_cnt = 8'd0;
          end else begin
            nxt_o.tick_cnt = tick_inc;
          end
        end
        i2cram_pkg::PhRdB: begin
          nxt_o.tick_cnt = tick_inc;
          if (elapsed) begin
            nxt_o.shift    = shift_in;
            nxt_o.bit_cnt  = bit_inc;
            nxt_o.tick_cnt = 8'd0;
            if (bit_inc >= i2cram_pkg::BitsPerByte) begin
              nxt_o.read_byte = shift_in;
              nxt_o.phase     = i2cram_pkg::PhNkA;
            end else begin
              nxt_o.phase = i2cram_pkg::PhRdA;
            end
          end
        end
        i2cram_pkg::PhStopC: begin
          nxt_o.tick_cnt = tick_inc;
          if (elapsed) begin
            nxt_o.phase    = i2cram_pkg::PhIdle;
            nxt_o.tick_cnt = 8'd0;
            done           = 1'b1;
          end
        end
        default: begin
          nxt_o.phase    = i2cram_pkg::PhIdle;
          nxt_o.tick_cnt = 8'd0;
        end
      endcase
    end
  end

  // Line levels and status after this step
  always_comb begin
    res_o.sda_drive = 1'b1;
    res_o.sda_out   = 1'b1;
    res_o.scl       = 1'b1;
    case (nxt_o.phase)
      i2cram_pkg::PhStartB: begin
        res_o.sda_out = 1'b0;
      end
      i2cram_pkg::PhStartC, i2cram_pkg::PhStopA: begin
        res_o.sda_out = 1'b0;
        res_o.scl     = 1'b0;
      end
      i2cram_pkg::PhBitA, i2cram_pkg::PhBitC: begin
        res_o.sda_out = nxt_o.shift[7];
        res_o.scl     = 1'b0;
      end
      i2cram_pkg::PhBitB: begin
        res_o.sda_out = nxt_o.shift[7];
      end
      i2cram_pkg::PhAckA, i2cram_pkg::PhRdA: begin
        res_o.sda_drive = 1'b0;
        res_o.scl       = 1'b0;
      end
      i2cram_pkg::PhAckB, i2cram_pkg::PhAckPoll, i2cram_pkg::PhRdB: begin
        res_o.sda_drive = 1'b0;
      end
      i2cram_pkg::PhNkA: begin
        res_o.scl = 1'b0;
      end
      i2cram_pkg::PhStopB: begin
        res_o.sda_out = 1'b0;
      end
      default: begin
        res_o.sda_drive = 1'b1;
      end
    endcase
    res_o.busy      = nxt_o.phase != i2cram_pkg::PhIdle;
    res_o.done      = done;
    res_o.ack_error = nxt_o.err;
    res_o.rdata     = nxt_o.read_byte;
  end

endmodule

`default_nettype wire

@@ hw/rtl/i2c_register_access_master_core.sv @@
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   op, dev_addr, reg_addr, wdata, sda_in
// out       output     out_valid_o / out_ready_i scl, sda_out, sda_drive, busy_res,
//                                                done_res, ack_error, rdata
// cfg       input      cfg_we_i (no wait)        cfg_index_i, cfg_wdata_i
//
// One item per cycle unless out_ready_i stalls the output: every accepted item
// updates the sequencer state and the output register in the same edge.
// Input is taken whenever the output register is empty or being drained.
// Reset returns the timing registers to their defaults and the sequencer to idle;
// the line outputs are not reset (idle drives SCL high, SDA driven high).
module i2c_register_access_master_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] op_i,
  input  wire logic [6:0] dev_addr_i,
  input  wire logic [7:0] reg_addr_i,
  input  wire logic [7:0] wdata_i,
  input  wire logic       sda_in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            scl_o,
  output logic            sda_out_o,
  output logic            sda_drive_o,
  output logic            busy_res_o,
  output logic            done_res_o,
  output logic            ack_error_o,
  output logic [7:0]      rdata_o,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [7:0] cfg_wdata_i
);

  i2cram_pkg::cfg_t   cfg_q;
  i2cram_pkg::state_t state_q, state_d;
  i2cram_pkg::res_t   res_q, res_d;
  logic               out_valid_q;
  logic               in_xfer;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setup       <= i2cram_pkg::SetupReset;
      cfg_q.write_bit   <= i2cram_pkg::WriteBitReset;
      cfg_q.read_bit    <= i2cram_pkg::ReadBitReset;
      cfg_q.master_ack  <= i2cram_pkg::MasterAckReset;
      cfg_q.ack_timeout <= i2cram_pkg::AckTimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        i2cram_pkg::CfgSetup:      cfg_q.setup       <= cfg_wdata_i;
        i2cram_pkg::CfgWriteBit:   cfg_q.write_bit   <= cfg_wdata_i;
        i2cram_pkg::CfgReadBit:    cfg_q.read_bit    <= cfg_wdata_i;
        i2cram_pkg::CfgMasterAck:  cfg_q.master_ack  <= cfg_wdata_i;
        i2cram_pkg::CfgAckTimeout: cfg_q.ack_timeout <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  i2cram_step u_step (
    .cur_i      (state_q),
    .cfg_i      (cfg_q),
    .op_i       (op_i),
    .dev_addr_i (dev_addr_i),
    .reg_addr_i (reg_addr_i),
    .wdata_i    (wdata_i),
    .sda_in_i   (sda_in_i),
    .nxt_o      (state_d),
    .res_o      (res_d)
  );

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= i2cram_pkg::PhIdle;
      state_q.tick_cnt  <= 8'd0;
      state_q.bit_cnt   <= 4'd0;
      state_q.byte_idx  <= i2cram_pkg::ByteDev;
      state_q.shift     <= 8'd0;
      state_q.is_read   <= 1'b0;
      state_q.dev_addr  <= 7'd0;
      state_q.reg_addr  <= 8'd0;
      state_q.wdata     <= 8'd0;
      state_q.read_byte <= 8'd0;
      state_q.err       <= 1'b0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_o       = res_q.scl;
  assign sda_out_o   = res_q.sda_out;
  assign sda_drive_o = res_q.sda_drive;
  assign busy_res_o  = res_q.busy;
  assign done_res_o  = res_q.done;
  assign ack_error_o = res_q.ack_error;
  assign rdata_o     = res_q.rdata;

endmodule

`default_nettype wire

@@ hw/rtl/i2cram_checker.sv @@
`default_nettype none

module i2cram_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       scl_o,
  input wire logic       sda_out_o,
  input wire logic       sda_drive_o,
  input wire logic       busy_res_o,
  input wire logic       done_res_o,
  input wire logic       ack_error_o,
  input wire logic [7:0] rdata_o
);

  // A finished transaction leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done reported while still busy");

  // Idle bus: SCL high and SDA driven high
  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> scl_o && sda_out_o && sda_drive_o)
    else $error("bus not released while idle");

  // Released SDA reads as high on the driven-level output
  a_release_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sda_drive_o |-> sda_out_o)
    else $error("sda_out low while released");

  // Input side keeps moving unless the result is stalled
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled with free output register");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rdata_o)
      && $stable(ack_error_o) && $stable(scl_o))
    else $error("stalled result changed");

endmodule

bind i2c_register_access_master_core i2cram_checker u_i2cram_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .scl_o       (scl_o),
  .sda_out_o   (sda_out_o),
  .sda_drive_o (sda_drive_o),
  .busy_res_o  (busy_res_o),
  .done_res_o  (done_res_o),
  .ack_error_o (ack_error_o),
  .rdata_o     (rdata_o)
);

`default_nettype wire
